// ===== rtl/tlb_pkg.sv =====
// ----------------------------------------------------------------------------
// tlb_pkg
// Shared types for the process-tagged translation cache: command codes and
// sequencer states.
// ----------------------------------------------------------------------------
package tlb_pkg;

	typedef enum logic [1:0] {
		CMD_LOOKUP    = 2'd0,
		CMD_INSERT    = 2'd1,
		CMD_FLUSH_PID = 2'd2,
		CMD_FLUSH_ALL = 2'd3
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_SCAN    = 5'b00010,
		ST_DECIDE  = 5'b00100,
		ST_PROMOTE = 5'b01000,
		ST_RESP    = 5'b10000
	} state_t;

endpackage

// ===== rtl/tlb_ifs.sv =====
// ----------------------------------------------------------------------------
// tlb_ifs
// Request and response channels of the translation cache, valid/ready.
// ----------------------------------------------------------------------------
interface tlb_req_if #(
	parameter int PID_BITS   = 8,
	parameter int PAGE_BITS  = 14,
	parameter int FRAME_BITS = 14
);
	logic                  valid;
	logic                  ready;
	tlb_pkg::cmd_t         cmd;
	logic [PID_BITS-1:0]   proc_id;
	logic [PAGE_BITS-1:0]  page_number;
	logic [FRAME_BITS-1:0] frame_number;

	modport source (output valid, cmd, proc_id, page_number, frame_number, input ready);
	modport sink   (input valid, cmd, proc_id, page_number, frame_number, output ready);
endinterface

interface tlb_rsp_if #(
	parameter int FRAME_BITS = 14,
	parameter int SLOT_BITS  = 4
);
	logic                  valid;
	logic                  ready;
	logic                  hit;
	logic [FRAME_BITS-1:0] found_frame;
	logic [SLOT_BITS-1:0]  slot;

	modport source (output valid, hit, found_frame, slot, input ready);
	modport sink   (input valid, hit, found_frame, slot, output ready);
endinterface

// ===== rtl/tlb_lru_translation_cache.sv =====
// ----------------------------------------------------------------------------
// tlb_lru_translation_cache
// Fully associative TLB with process-id tags and counter-based LRU.
//
//   channel  dir  transaction
//   req      in   cmd, proc_id, page_number, frame_number
//   rsp      out  hit, found_frame, slot
//
// One transaction at a time; req.ready is high only when idle.
// Lookup hit / insert: after acceptance, one tag-memory read per cycle over all
// entries, then one rank update per cycle over all entries, then the result.
// Lookup miss / pid flush: the scan only. Flush all: result without a scan.
// Reset clears all valid bits and loads each rank with its entry index.
// A stalled rsp holds the result and keeps req.ready low.
// ----------------------------------------------------------------------------
module tlb_lru_translation_cache #(
	parameter int ENTRIES    = 16,
	parameter int PID_BITS   = 8,
	parameter int PAGE_BITS  = 14,
	parameter int FRAME_BITS = 14
) (
	input  logic      clk,
	input  logic      arst_n,
	tlb_req_if.sink   req,
	tlb_rsp_if.source rsp
);

	localparam int SLOT_BITS = $clog2(ENTRIES);
	localparam int CNT_BITS  = $clog2(ENTRIES + 1);
	localparam int WORD_BITS = PID_BITS + PAGE_BITS + FRAME_BITS;
	localparam logic [SLOT_BITS-1:0] LAST_IDX = SLOT_BITS'(ENTRIES - 1);
	localparam logic [CNT_BITS-1:0]  CNT_END  = CNT_BITS'(ENTRIES);

	tlb_pkg::state_t state_q;
	tlb_pkg::cmd_t   cmd_q;
	logic [PID_BITS-1:0]   pid_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic [FRAME_BITS-1:0] new_frame_q;

	logic [CNT_BITS-1:0]  cnt_q;
	logic                 rd_vld_s1;
	logic [SLOT_BITS-1:0] rd_idx_s1;
	logic [WORD_BITS-1:0] rd_data_s1;

	logic [WORD_BITS-1:0] mem [ENTRIES];

	logic [ENTRIES-1:0]   valid_q;
	logic [SLOT_BITS-1:0] rank_q [ENTRIES];

	logic                 found_q;
	logic                 inv_found_q;
	logic                 zero_found_q;
	logic [SLOT_BITS-1:0] tgt_q;
	logic [SLOT_BITS-1:0] zero_idx_q;
	logic [SLOT_BITS-1:0] cur_rank_q;

	logic                  hit_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [SLOT_BITS-1:0]  slot_q;

	logic                  issue;
	logic                  accept;
	logic [SLOT_BITS-1:0]  cnt_idx;
	logic [SLOT_BITS-1:0]  rank_addr;
	logic [SLOT_BITS-1:0]  rank_rd;
	logic [SLOT_BITS-1:0]  victim;
	logic                  mem_we;
	logic [PID_BITS-1:0]   ent_pid;
	logic [PAGE_BITS-1:0]  ent_page;
	logic [FRAME_BITS-1:0] ent_frame;
	logic                  pid_eq;
	logic                  key_hit;

	assign accept    = req.valid && req.ready;
	assign cnt_idx   = cnt_q[SLOT_BITS-1:0];
	assign issue     = (state_q == tlb_pkg::ST_SCAN) && (cnt_q < CNT_END);
	assign rank_addr = (state_q == tlb_pkg::ST_PROMOTE) ? cnt_idx : rd_idx_s1;
	assign rank_rd   = rank_q[rank_addr];
	assign victim    = inv_found_q ? tgt_q : zero_idx_q;
	assign mem_we    = (state_q == tlb_pkg::ST_DECIDE) && (cmd_q == tlb_pkg::CMD_INSERT);

	assign ent_pid   = rd_data_s1[WORD_BITS-1 -: PID_BITS];
	assign ent_page  = rd_data_s1[FRAME_BITS +: PAGE_BITS];
	assign ent_frame = rd_data_s1[FRAME_BITS-1:0];
	assign pid_eq    = (ent_pid == pid_q);
	assign key_hit   = valid_q[rd_idx_s1] && pid_eq && (ent_page == page_q);

	assign req.ready       = (state_q == tlb_pkg::ST_IDLE);
	assign rsp.valid       = (state_q == tlb_pkg::ST_RESP);
	assign rsp.hit         = hit_q;
	assign rsp.found_frame = frame_q;
	assign rsp.slot        = slot_q;

	// tag memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[victim] <= {pid_q, page_q, new_frame_q};
		end
		rd_data_s1 <= mem[cnt_idx];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= req.cmd;
			pid_q       <= req.proc_id;
			page_q      <= req.page_number;
			new_frame_q <= req.frame_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tlb_pkg::ST_IDLE;
			cnt_q        <= '0;
			rd_vld_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			valid_q      <= '0;
			found_q      <= 1'b0;
			inv_found_q  <= 1'b0;
			zero_found_q <= 1'b0;
			tgt_q        <= '0;
			zero_idx_q   <= '0;
			cur_rank_q   <= '0;
			hit_q        <= 1'b0;
			frame_q      <= '0;
			slot_q       <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= SLOT_BITS'(i);
			end
		end else begin
			rd_vld_s1 <= issue;
			rd_idx_s1 <= cnt_idx;
			case (state_q)
				tlb_pkg::ST_IDLE: begin
					if (accept) begin
						cnt_q        <= '0;
						found_q      <= 1'b0;
						inv_found_q  <= 1'b0;
						zero_found_q <= 1'b0;
						hit_q        <= 1'b0;
						frame_q      <= '0;
						slot_q       <= '0;
						if (req.cmd == tlb_pkg::CMD_FLUSH_ALL) begin
							valid_q <= '0;
							state_q <= tlb_pkg::ST_RESP;
						end else begin
							state_q <= tlb_pkg::ST_SCAN;
						end
					end
				end
				tlb_pkg::ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (rd_vld_s1) begin
						case (cmd_q)
							tlb_pkg::CMD_LOOKUP: begin
								if (key_hit && !found_q) begin
									found_q    <= 1'b1;
									tgt_q      <= rd_idx_s1;
									cur_rank_q <= rank_rd;
									frame_q    <= ent_frame;
								end
							end
							tlb_pkg::CMD_INSERT: begin
								if (!valid_q[rd_idx_s1] && !inv_found_q) begin
									inv_found_q <= 1'b1;
									tgt_q       <= rd_idx_s1;
									cur_rank_q  <= rank_rd;
								end
								if (rank_rd == '0 && !zero_found_q) begin
									zero_found_q <= 1'b1;
									zero_idx_q   <= rd_idx_s1;
								end
							end
							tlb_pkg::CMD_FLUSH_PID: begin
								if (pid_eq) begin
									valid_q[rd_idx_s1] <= 1'b0;
								end
							end
							default: begin
							end
						endcase
						if (rd_idx_s1 == LAST_IDX) begin
							state_q <= tlb_pkg::ST_DECIDE;
						end
					end
				end
				tlb_pkg::ST_DECIDE: begin
					cnt_q <= '0;
					case (cmd_q)
						tlb_pkg::CMD_LOOKUP: begin
							hit_q   <= found_q;
							slot_q  <= found_q ? tgt_q : '0;
							state_q <= found_q ? tlb_pkg::ST_PROMOTE : tlb_pkg::ST_RESP;
						end
						tlb_pkg::CMD_INSERT: begin
							valid_q[victim] <= 1'b1;
							tgt_q           <= victim;
							cur_rank_q      <= inv_found_q ? cur_rank_q : '0;
							slot_q          <= victim;
							state_q         <= tlb_pkg::ST_PROMOTE;
						end
						default: begin
							state_q <= tlb_pkg::ST_RESP;
						end
					endcase
				end
				tlb_pkg::ST_PROMOTE: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_idx == tgt_q) begin
						rank_q[cnt_idx] <= LAST_IDX;
					end else if (rank_rd > cur_rank_q) begin
						rank_q[cnt_idx] <= rank_rd - 1'b1;
					end
					if (cnt_idx == LAST_IDX) begin
						state_q <= tlb_pkg::ST_RESP;
					end
				end
				tlb_pkg::ST_RESP: begin
					if (rsp.ready) begin
						state_q <= tlb_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tlb_pkg::ST_IDLE;
				end
			endcase
		end
	end

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !rsp.valid)
		else $error("request and response both open");

	a_hit_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.hit |-> cmd_q == tlb_pkg::CMD_LOOKUP)
		else $error("hit reported for non-lookup");

	a_insert_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> valid_q[tgt_q])
		else $error("inserted entry not valid");

	a_flush_all: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.cmd == tlb_pkg::CMD_FLUSH_ALL |=> valid_q == '0)
		else $error("flush all left valid entries");

	a_miss_frame: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.hit |-> rsp.found_frame == '0)
		else $error("frame on miss");

endmodule

// ===== tb/tlb_lru_translation_cache_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_lru_translation_cache_tb
// Self-checking bench for the process-tagged LRU translation cache. A short
// table of directed transactions, partly with typed-in responses, is followed
// by random lookup/insert/flush traffic in four phases of source and sink
// idling. Responses are checked against typed-in values or a local LRU predictor.
// ----------------------------------------------------------------------------
module tlb_lru_translation_cache_tb;

	localparam int ENTRIES         = 16;
	localparam int PID_W           = 8;
	localparam int PAGE_W          = 14;
	localparam int FRAME_W         = 14;
	localparam int SLOT_W          = 4;
	localparam int DIR_ROWS        = 22;
	localparam int RAND_PER_PHASE  = 185;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 2 * ENTRIES + 8;
	localparam int WATCHDOG_CYCLES = 4000;
	localparam int MAX_REPORTS     = 10;
	localparam int RECENT_DEPTH    = 32;

	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] frame;
		logic [SLOT_W-1:0]  slot;
	} xlate_rsp_t;

	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [PAGE_W-1:0] page;
	} vmap_t;

	typedef struct {
		tlb_pkg::cmd_t      cmd;
		logic [PID_W-1:0]   pid;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
		bit                 typed;
		logic               hit;
		logic [FRAME_W-1:0] found;
		logic [SLOT_W-1:0]  slot;
	} dir_row_t;

	logic clk;
	logic arst_n;

	tlb_req_if #(.PID_BITS(PID_W), .PAGE_BITS(PAGE_W), .FRAME_BITS(FRAME_W)) req_ch ();
	tlb_rsp_if #(.FRAME_BITS(FRAME_W), .SLOT_BITS(SLOT_W)) rsp_ch ();

	tlb_lru_translation_cache #(
		.ENTRIES   (ENTRIES),
		.PID_BITS  (PID_W),
		.PAGE_BITS (PAGE_W),
		.FRAME_BITS(FRAME_W)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// predictor state
	logic               ent_valid [ENTRIES];
	logic [PID_W-1:0]   ent_pid   [ENTRIES];
	logic [PAGE_W-1:0]  ent_page  [ENTRIES];
	logic [FRAME_W-1:0] ent_frame [ENTRIES];
	logic [SLOT_W-1:0]  ent_rank  [ENTRIES];

	xlate_rsp_t pending_rsp [$];
	vmap_t      recent_maps [$];

	bit         row_typed;
	xlate_rsp_t row_want;
	int         gap_pct;
	int         stall_pct;
	bit         hold_start;
	int         mismatches;
	int         quiet_cycles;

	dir_row_t script [DIR_ROWS] = '{
		'{tlb_pkg::CMD_LOOKUP,    8'h00, 14'h0000, 14'h0000, 1'b1, 1'b0, 14'h0000, 4'd0},
		'{tlb_pkg::CMD_INSERT,    8'h00, 14'h0000, 14'h0000, 1'b1, 1'b0, 14'h0000, 4'd0},
		'{tlb_pkg::CMD_INSERT,    8'hFF, 14'h3FFF, 14'h3FFF, 1'b1, 1'b0, 14'h0000, 4'd1},
		'{tlb_pkg::CMD_LOOKUP,    8'hFF, 14'h3FFF, 14'h0000, 1'b1, 1'b1, 14'h3FFF, 4'd1},
		'{tlb_pkg::CMD_LOOKUP,    8'h00, 14'h0000, 14'h3FFF, 1'b1, 1'b1, 14'h0000, 4'd0},
		'{tlb_pkg::CMD_LOOKUP,    8'hFF, 14'h0000, 14'h0000, 1'b1, 1'b0, 14'h0000, 4'd0},
		'{tlb_pkg::CMD_LOOKUP,    8'h00, 14'h3FFF, 14'h0000, 1'b1, 1'b0, 14'h0000, 4'd0},
		'{tlb_pkg::CMD_INSERT,    8'hFF, 14'h3FFF, 14'h1555, 1'b1, 1'b0, 14'h0000, 4'd2},
		'{tlb_pkg::CMD_LOOKUP,    8'hFF, 14'h3FFF, 14'h0000, 1'b0, 1'b0, 14'h0000, 4'd0},
		'{tlb_pkg::CMD_FLUSH_PID, 8'hFF, 14'h0000, 14'h0000, 1'b1, 1'b0, 14'h0000, 4'd0},
		'{tlb_pkg::CMD_LOOKUP,    8'hFF, 14'h3FFF, 14'h0000, 1'b1, 1'b0, 14'h0000, 4'd0},
		'{tlb_pkg::CMD_LOOKUP,    8'h00, 14'h0000, 14'h0000, 1'b0, 1'b0, 14'h0000, 4'd0},
		'{tlb_pkg::CMD_INSERT,    8'hAA, 14'h2AAA, 14'h1555, 1'b1, 1'b0, 14'h0000, 4'd1},
		'{tlb_pkg::CMD_INSERT,    8'h55, 14'h1555, 14'h2AAA, 1'b1, 1'b0, 14'h0000, 4'd2},
		'{tlb_pkg::CMD_LOOKUP,    8'h55, 14'h1555, 14'h0000, 1'b1, 1'b1, 14'h2AAA, 4'd2},
		'{tlb_pkg::CMD_FLUSH_PID, 8'h80, 14'h3FFF, 14'h3FFF, 1'b1, 1'b0, 14'h0000, 4'd0},
		'{tlb_pkg::CMD_LOOKUP,    8'hAA, 14'h2AAA, 14'h0000, 1'b0, 1'b0, 14'h0000, 4'd0},
		'{tlb_pkg::CMD_FLUSH_ALL, 8'hFF, 14'h3FFF, 14'h3FFF, 1'b1, 1'b0, 14'h0000, 4'd0},
		'{tlb_pkg::CMD_LOOKUP,    8'hAA, 14'h2AAA, 14'h0000, 1'b1, 1'b0, 14'h0000, 4'd0},
		'{tlb_pkg::CMD_INSERT,    8'h01, 14'h0001, 14'h0001, 1'b1, 1'b0, 14'h0000, 4'd0},
		'{tlb_pkg::CMD_LOOKUP,    8'h01, 14'h0001, 14'h3FFF, 1'b1, 1'b1, 14'h0001, 4'd0},
		'{tlb_pkg::CMD_FLUSH_PID, 8'h00, 14'h0000, 14'h0000, 1'b0, 1'b0, 14'h0000, 4'd0}
	};

	function automatic void touch_entry(int idx);
		logic [SLOT_W-1:0] cur;
		cur = ent_rank[idx];
		for (int i = 0; i < ENTRIES; i++) begin
			if (ent_rank[i] > cur)
				ent_rank[i]--;
		end
		ent_rank[idx] = SLOT_W'(ENTRIES - 1);
	endfunction

	function automatic int choose_victim();
		int best;
		best = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!ent_valid[i])
				return i;
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (ent_rank[i] == '0)
				return i;
		end
		for (int i = 1; i < ENTRIES; i++) begin
			if (ent_rank[i] < ent_rank[best])
				best = i;
		end
		return best;
	endfunction

	function automatic xlate_rsp_t apply_request(tlb_pkg::cmd_t c, logic [PID_W-1:0] p,
			logic [PAGE_W-1:0] pg, logic [FRAME_W-1:0] fr);
		xlate_rsp_t r;
		int v;
		r = '0;
		case (c)
			tlb_pkg::CMD_LOOKUP: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (ent_valid[i] && ent_pid[i] == p && ent_page[i] == pg) begin
						r.hit   = 1'b1;
						r.frame = ent_frame[i];
						r.slot  = SLOT_W'(i);
						touch_entry(i);
						break;
					end
				end
			end
			tlb_pkg::CMD_INSERT: begin
				v = choose_victim();
				ent_pid[v]   = p;
				ent_page[v]  = pg;
				ent_frame[v] = fr;
				ent_valid[v] = 1'b1;
				touch_entry(v);
				r.slot = SLOT_W'(v);
			end
			tlb_pkg::CMD_FLUSH_PID: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (ent_pid[i] == p)
						ent_valid[i] = 1'b0;
				end
			end
			default: begin
				for (int i = 0; i < ENTRIES; i++)
					ent_valid[i] = 1'b0;
			end
		endcase
		return r;
	endfunction

	task automatic issue(tlb_pkg::cmd_t c, logic [PID_W-1:0] p, logic [PAGE_W-1:0] pg,
			logic [FRAME_W-1:0] fr, bit typed, xlate_rsp_t want);
		int gap;
		gap = 0;
		while (gap < 200 && $urandom_range(99) < gap_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.cmd          <= c;
		req_ch.proc_id      <= p;
		req_ch.page_number  <= pg;
		req_ch.frame_number <= fr;
		row_typed           <= typed;
		row_want            <= want;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// sink side: random stalls plus one long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_start) begin
				hold_start = 1'b0;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		xlate_rsp_t want;
		xlate_rsp_t got;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display({"%0t: response with no transaction outstanding: ",
						"hit=%0b frame=%h slot=%0d"},
						$realtime, rsp_ch.hit, rsp_ch.found_frame, rsp_ch.slot);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.hit !== want.hit || rsp_ch.found_frame !== want.frame ||
						rsp_ch.slot !== want.slot) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"%0t: mismatch: expected hit=%0b frame=%h slot=%0d, ",
							"got hit=%0b frame=%h slot=%0d"},
							$realtime, want.hit, want.frame, want.slot,
							rsp_ch.hit, rsp_ch.found_frame, rsp_ch.slot);
				end
			end
		end
		if (req_ch.valid && req_ch.ready) begin
			got = apply_request(req_ch.cmd, req_ch.proc_id, req_ch.page_number,
				req_ch.frame_number);
			pending_rsp.push_back(row_typed ? row_want : got);
		end
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_CYCLES);
		$display("FAIL");
		$finish;
	end

	initial begin
		int                 gap_sched   [4];
		int                 stall_sched [4];
		int                 pick;
		tlb_pkg::cmd_t      c;
		logic [PID_W-1:0]   p;
		logic [PAGE_W-1:0]  pg;
		logic [FRAME_W-1:0] fr;
		vmap_t              vm;
		xlate_rsp_t         want;

		gap_sched           = '{0, 86, 0, 35};
		stall_sched         = '{0, 0, 86, 35};
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.cmd          = tlb_pkg::CMD_LOOKUP;
		req_ch.proc_id      = '0;
		req_ch.page_number  = '0;
		req_ch.frame_number = '0;
		row_typed           = 1'b0;
		row_want            = '0;
		gap_pct             = 0;
		stall_pct           = 0;
		hold_start          = 1'b0;
		mismatches          = 0;
		quiet_cycles        = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			ent_valid[i] = 1'b0;
			ent_pid[i]   = '0;
			ent_page[i]  = '0;
			ent_frame[i] = '0;
			ent_rank[i]  = SLOT_W'(i);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			want.hit   = script[r].hit;
			want.frame = script[r].found;
			want.slot  = script[r].slot;
			issue(script[r].cmd, script[r].pid, script[r].page, script[r].frame,
				script[r].typed, want);
		end
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			gap_pct   = gap_sched[ph];
			stall_pct = stall_sched[ph];
			if (ph == 0)
				hold_start = 1'b1;
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				pick = $urandom_range(99);
				fr   = FRAME_W'($urandom);
				p    = ($urandom_range(3) == 0) ? PID_W'($urandom) : PID_W'($urandom_range(7));
				pg   = ($urandom_range(1) == 0) ? PAGE_W'($urandom) : PAGE_W'($urandom_range(31));
				if (pick < 45) begin
					c       = tlb_pkg::CMD_INSERT;
					vm.pid  = p;
					vm.page = pg;
					recent_maps.push_back(vm);
					if (recent_maps.size() > RECENT_DEPTH)
						void'(recent_maps.pop_front());
				end else if (pick < 88) begin
					c = tlb_pkg::CMD_LOOKUP;
					if (recent_maps.size() > 0 && $urandom_range(9) < 7) begin
						vm = recent_maps[$urandom_range(recent_maps.size() - 1)];
						p  = vm.pid;
						pg = vm.page;
					end
				end else if (pick < 98) begin
					c = tlb_pkg::CMD_FLUSH_PID;
					if (recent_maps.size() > 0 && $urandom_range(1) == 0)
						p = recent_maps[$urandom_range(recent_maps.size() - 1)].pid;
				end else begin
					c = tlb_pkg::CMD_FLUSH_ALL;
				end
				issue(c, p, pg, fr, 1'b0, '0);
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
